// File: sv/fsmm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the fuzzy spin motor mixer.
// No dependencies; every other file of the block imports this package.
package fsmm_pkg;

    localparam int ZERO_BITS       = 16;
    localparam int SAT_LOW_BITS    = 16;
    localparam int SAT_HIGH_BITS   = 15;
    localparam int OFFSET_BITS     = 8;
    localparam int LOAD_BITS       = 8;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = 16;
    localparam int STATIC_HALF     = 4;
    // The error magnitude inside a sloped region of an outer set fits here.
    localparam int SLOPE_SPAN_BITS = 15;
    localparam int FRONT_STAGES    = 5;
    localparam int DIV_STAGES      = LOAD_BITS;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t REG_ZERO_READING       = 3'd0;
    localparam cfg_index_t REG_SAT_LOW            = 3'd1;
    localparam cfg_index_t REG_SAT_HIGH           = 3'd2;
    localparam cfg_index_t REG_CW_NEUTRAL_OFFSET  = 3'd3;
    localparam cfg_index_t REG_CW_FAST_OFFSET     = 3'd4;
    localparam cfg_index_t REG_CCW_NEUTRAL_OFFSET = 3'd5;
    localparam cfg_index_t REG_CCW_FAST_OFFSET    = 3'd6;

    typedef logic signed [OFFSET_BITS-1:0] offset_t;

    typedef struct packed {
        offset_t cw_neutral;
        offset_t cw_fast;
        offset_t ccw_neutral;
        offset_t ccw_fast;
    } offsets_t;

    typedef enum logic {
        SL_IDLE,
        SL_RUN
    } slope_state_t;

endpackage

// File: sv/fsmm_slope.sv
`timescale 1ns / 1ps
// Slope unit: restoring division of WEIGHT_MAX by the two saturation points.
// Depends on fsmm_pkg; runs after reset and after each saturation write.
module fsmm_slope import fsmm_pkg::*; #(
    parameter int WEIGHT_MAX = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 restart,
    input  logic signed [SAT_LOW_BITS-1:0]       sat_low,
    input  logic        [SAT_HIGH_BITS-1:0]      sat_high,
    output logic                                 busy,
    output logic [$clog2(WEIGHT_MAX+1)-1:0]      q_lo,
    output logic [$clog2(WEIGHT_MAX+1)-1:0]      q_hi
);

    localparam int QB = $clog2(WEIGHT_MAX + 1);
    localparam int CW = $clog2(QB);
    localparam int DB = SAT_LOW_BITS + 1;
    localparam int RB = DB + 1;

    localparam logic [QB-1:0] WM_BITS = QB'(WEIGHT_MAX);

    slope_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [RB-1:0] rem_lo_reg, rem_lo_next;
    logic [RB-1:0] rem_hi_reg, rem_hi_next;
    logic [QB-1:0] q_lo_reg, q_lo_next;
    logic [QB-1:0] q_hi_reg, q_hi_next;

    logic signed [DB-1:0] sl_ext;
    logic [DB-1:0] d_lo;
    logic [DB-1:0] d_hi;
    logic [RB-1:0] trial_lo;
    logic [RB-1:0] trial_hi;
    logic ge_lo;
    logic ge_hi;

    // A non-negative sat_low gives a divisor that is never used downstream.
    assign sl_ext = {sat_low[SAT_LOW_BITS-1], sat_low};
    assign d_lo   = DB'(-sl_ext);
    assign d_hi   = {{(DB-SAT_HIGH_BITS){1'b0}}, sat_high};

    assign trial_lo = {rem_lo_reg[RB-2:0], WM_BITS[cnt_reg]};
    assign trial_hi = {rem_hi_reg[RB-2:0], WM_BITS[cnt_reg]};
    assign ge_lo    = trial_lo >= {1'b0, d_lo};
    assign ge_hi    = trial_hi >= {1'b0, d_hi};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SL_IDLE: begin
                if (restart) begin
                    state_next = SL_RUN;
                end
            end
            SL_RUN: begin
                if (!restart && cnt_reg == '0) begin
                    state_next = SL_IDLE;
                end
            end
            default: state_next = SL_RUN;
        endcase
    end

    always_comb begin
        case (state_reg)
            SL_IDLE: busy = 1'b0;
            default: busy = 1'b1;
        endcase
    end

    always_comb begin
        cnt_next    = cnt_reg;
        rem_lo_next = rem_lo_reg;
        rem_hi_next = rem_hi_reg;
        q_lo_next   = q_lo_reg;
        q_hi_next   = q_hi_reg;
        if (restart) begin
            cnt_next    = CW'(QB - 1);
            rem_lo_next = '0;
            rem_hi_next = '0;
        end else if (state_reg == SL_RUN) begin
            cnt_next    = cnt_reg - 1'b1;
            rem_lo_next = ge_lo ? trial_lo - {1'b0, d_lo} : trial_lo;
            rem_hi_next = ge_hi ? trial_hi - {1'b0, d_hi} : trial_hi;
            q_lo_next   = {q_lo_reg[QB-2:0], ge_lo};
            q_hi_next   = {q_hi_reg[QB-2:0], ge_hi};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= SL_RUN;
            cnt_reg    <= CW'(QB - 1);
            rem_lo_reg <= '0;
            rem_hi_reg <= '0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rem_lo_reg <= rem_lo_next;
            rem_hi_reg <= rem_hi_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_lo_reg <= q_lo_next;
        q_hi_reg <= q_hi_next;
    end

    assign q_lo = q_lo_reg;
    assign q_hi = q_hi_reg;

endmodule

// File: sv/fsmm_weight.sv
`timescale 1ns / 1ps
// Error and membership weights: pipeline stages one and two.
// Depends on fsmm_pkg and on the slope quotients from fsmm_slope.
module fsmm_weight import fsmm_pkg::*; #(
    parameter int WEIGHT_MAX   = 1024,
    parameter int READING_BITS = 16
) (
    input  logic                                 aclk,
    input  logic [1:0]                           stage_en,
    input  logic [READING_BITS-1:0]              reading,
    input  logic [ZERO_BITS-1:0]                 zero_reading,
    input  logic signed [SAT_LOW_BITS-1:0]       sat_low,
    input  logic [SAT_HIGH_BITS-1:0]             sat_high,
    input  logic [$clog2(WEIGHT_MAX+1)-1:0]      q_lo,
    input  logic [$clog2(WEIGHT_MAX+1)-1:0]      q_hi,
    output logic [$clog2(WEIGHT_MAX+1)-1:0]      w_cw,
    output logic [$clog2(WEIGHT_MAX+1)-1:0]      w_static,
    output logic [$clog2(WEIGHT_MAX+1)-1:0]      w_ccw
);

    localparam int WB      = $clog2(WEIGHT_MAX + 1);
    localparam int VB      = (READING_BITS > ZERO_BITS) ? READING_BITS : ZERO_BITS;
    localparam int EW      = VB + 1;
    localparam int QUARTER = WEIGHT_MAX / STATIC_HALF;

    logic signed [EW-1:0] err_reg, err_next;
    logic [EW-1:0]        mag_reg, mag_next;
    logic [WB-1:0]        w_cw_reg, w_cw_next;
    logic [WB-1:0]        w_static_reg, w_static_next;
    logic [WB-1:0]        w_ccw_reg, w_ccw_next;

    logic signed [EW-1:0] z_ext;
    logic signed [EW-1:0] r_ext;
    logic signed [EW-1:0] pos_diff;
    logic signed [EW-1:0] neg_diff;
    logic [WB-1:0]        q_sel;
    logic [WB+SLOPE_SPAN_BITS-1:0] prod;
    logic [WB-1:0]        slope_w;
    logic                 at_or_below_lo;
    logic                 at_or_above_hi;
    logic [2:0]           steps_left;

    // Both differences are formed at once so that the magnitude is a mux.
    assign z_ext    = $signed({{(EW-ZERO_BITS){1'b0}}, zero_reading});
    assign r_ext    = $signed({{(EW-READING_BITS){1'b0}}, reading});
    assign pos_diff = z_ext - r_ext;
    assign neg_diff = r_ext - z_ext;
    assign err_next = pos_diff;
    assign mag_next = pos_diff[EW-1] ? neg_diff : pos_diff;

    // The two sloped regions meet only at zero error, where the product is zero.
    assign q_sel   = err_reg[EW-1] ? q_lo : q_hi;
    assign prod    = q_sel * mag_reg[SLOPE_SPAN_BITS-1:0];
    assign slope_w = prod[WB-1:0];

    assign at_or_below_lo = err_reg <= $signed({{(EW-SAT_LOW_BITS){sat_low[SAT_LOW_BITS-1]}},
                                               sat_low});
    assign at_or_above_hi = err_reg >= $signed({{(EW-SAT_HIGH_BITS){1'b0}}, sat_high});

    assign steps_left = 3'(STATIC_HALF) - mag_reg[2:0];

    always_comb begin
        if (at_or_below_lo) begin
            w_cw_next = WB'(WEIGHT_MAX);
        end else if (!err_reg[EW-1] && err_reg != '0) begin
            w_cw_next = '0;
        end else begin
            w_cw_next = slope_w;
        end

        if (at_or_above_hi) begin
            w_ccw_next = WB'(WEIGHT_MAX);
        end else if (err_reg[EW-1]) begin
            w_ccw_next = '0;
        end else begin
            w_ccw_next = slope_w;
        end

        if (mag_reg <= EW'(STATIC_HALF)) begin
            w_static_next = WB'(WB'(QUARTER) * {{(WB-3){1'b0}}, steps_left});
        end else begin
            w_static_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            err_reg <= err_next;
            mag_reg <= mag_next;
        end
        if (stage_en[1]) begin
            w_cw_reg     <= w_cw_next;
            w_static_reg <= w_static_next;
            w_ccw_reg    <= w_ccw_next;
        end
    end

    assign w_cw     = w_cw_reg;
    assign w_static = w_static_reg;
    assign w_ccw    = w_ccw_reg;

endmodule

// File: sv/fsmm_mix.sv
`timescale 1ns / 1ps
// Weighted sums of the rule offsets: pipeline stages three to five.
// Depends on fsmm_pkg; feeds sign-magnitude dividends to fsmm_div.
module fsmm_mix import fsmm_pkg::*; #(
    parameter int WEIGHT_MAX = 1024
) (
    input  logic                                      aclk,
    input  logic [2:0]                                stage_en,
    input  offsets_t                                  offsets,
    input  logic [$clog2(WEIGHT_MAX+1)-1:0]           w_cw,
    input  logic [$clog2(WEIGHT_MAX+1)-1:0]           w_static,
    input  logic [$clog2(WEIGHT_MAX+1)-1:0]           w_ccw,
    output logic [$clog2(WEIGHT_MAX+1)+1:0]           w_sum,
    output logic [$clog2(WEIGHT_MAX+1)+OFFSET_BITS+2:0] cw_mag,
    output logic [$clog2(WEIGHT_MAX+1)+OFFSET_BITS+2:0] ccw_mag,
    output logic                                      cw_neg,
    output logic                                      ccw_neg,
    output logic                                      no_weight
);

    localparam int WB  = $clog2(WEIGHT_MAX + 1);
    localparam int WSB = WB + 2;
    localparam int PB  = WB + 1 + OFFSET_BITS;
    localparam int SB  = PB + 2;

    logic signed [WB:0] w0s;
    logic signed [WB:0] w1s;
    logic signed [WB:0] w2s;

    // Stage three: six products and the weight sum.
    logic signed [PB-1:0] p_cw0_reg, p_cw1_reg, p_cw2_reg;
    logic signed [PB-1:0] p_ccw0_reg, p_ccw1_reg, p_ccw2_reg;
    logic [WSB-1:0]       ws3_reg, ws3_next;
    // Stage four: signed sums.
    logic signed [SB-1:0] cw_sum_reg, cw_sum_next;
    logic signed [SB-1:0] ccw_sum_reg, ccw_sum_next;
    logic [WSB-1:0]       ws4_reg;
    // Stage five: sign and magnitude.
    logic [SB-1:0]        cw_mag_reg, ccw_mag_reg;
    logic                 cw_neg_reg, ccw_neg_reg, none_reg;
    logic [WSB-1:0]       ws5_reg;

    assign w0s = $signed({1'b0, w_cw});
    assign w1s = $signed({1'b0, w_static});
    assign w2s = $signed({1'b0, w_ccw});

    assign ws3_next = WSB'(w_cw) + WSB'(w_static) + WSB'(w_ccw);

    assign cw_sum_next  = SB'(p_cw0_reg) + SB'(p_cw1_reg) + SB'(p_cw2_reg);
    assign ccw_sum_next = SB'(p_ccw0_reg) + SB'(p_ccw1_reg) + SB'(p_ccw2_reg);

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            p_cw0_reg  <= w0s * offsets.cw_neutral;
            p_cw1_reg  <= w1s * offsets.cw_neutral;
            p_cw2_reg  <= w2s * offsets.cw_fast;
            p_ccw0_reg <= w0s * offsets.ccw_fast;
            p_ccw1_reg <= w1s * offsets.ccw_neutral;
            p_ccw2_reg <= w2s * offsets.ccw_neutral;
            ws3_reg    <= ws3_next;
        end
        if (stage_en[1]) begin
            cw_sum_reg  <= cw_sum_next;
            ccw_sum_reg <= ccw_sum_next;
            ws4_reg     <= ws3_reg;
        end
        if (stage_en[2]) begin
            cw_mag_reg  <= cw_sum_reg[SB-1] ? SB'(-cw_sum_reg) : SB'(cw_sum_reg);
            ccw_mag_reg <= ccw_sum_reg[SB-1] ? SB'(-ccw_sum_reg) : SB'(ccw_sum_reg);
            cw_neg_reg  <= cw_sum_reg[SB-1];
            ccw_neg_reg <= ccw_sum_reg[SB-1];
            none_reg    <= ws4_reg == '0;
            ws5_reg     <= ws4_reg;
        end
    end

    assign w_sum     = ws5_reg;
    assign cw_mag    = cw_mag_reg;
    assign ccw_mag   = ccw_mag_reg;
    assign cw_neg    = cw_neg_reg;
    assign ccw_neg   = ccw_neg_reg;
    assign no_weight = none_reg;

endmodule

// File: sv/fsmm_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, for both loads.
// Depends on fsmm_pkg; takes sign-magnitude dividends from fsmm_mix.
module fsmm_div import fsmm_pkg::*; #(
    parameter int WEIGHT_MAX = 1024
) (
    input  logic                                        aclk,
    input  logic [DIV_STAGES-1:0]                       stage_en,
    input  logic [$clog2(WEIGHT_MAX+1)+1:0]             w_sum,
    input  logic [$clog2(WEIGHT_MAX+1)+OFFSET_BITS+2:0] cw_mag,
    input  logic [$clog2(WEIGHT_MAX+1)+OFFSET_BITS+2:0] ccw_mag,
    input  logic                                        cw_neg,
    input  logic                                        ccw_neg,
    input  logic                                        no_weight,
    output logic [LOAD_BITS-1:0]                        cw_quot,
    output logic [LOAD_BITS-1:0]                        ccw_quot,
    output logic                                        cw_neg_out,
    output logic                                        ccw_neg_out,
    output logic                                        no_weight_out
);

    localparam int WB  = $clog2(WEIGHT_MAX + 1);
    localparam int WSB = WB + 2;
    localparam int SB  = WB + OFFSET_BITS + 3;

    logic [SB-1:0]        cw_rem_reg  [DIV_STAGES];
    logic [SB-1:0]        ccw_rem_reg [DIV_STAGES];
    logic [LOAD_BITS-1:0] cw_q_reg    [DIV_STAGES];
    logic [LOAD_BITS-1:0] ccw_q_reg   [DIV_STAGES];
    logic [WSB-1:0]       ws_reg      [DIV_STAGES];
    logic                 cw_neg_reg  [DIV_STAGES];
    logic                 ccw_neg_reg [DIV_STAGES];
    logic                 none_reg    [DIV_STAGES];

    // A weighted average of 8-bit offsets has a magnitude of at most 128,
    // so eight quotient bits cover every item.
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [SB-1:0]        cw_rem_in, ccw_rem_in, divisor_sh;
        logic [LOAD_BITS-1:0] cw_q_in, ccw_q_in;
        logic [WSB-1:0]       ws_in;
        logic                 cw_neg_in, ccw_neg_in, none_in;
        logic                 cw_ge, ccw_ge;

        if (k == 0) begin : g_first
            assign cw_rem_in  = cw_mag;
            assign ccw_rem_in = ccw_mag;
            assign cw_q_in    = '0;
            assign ccw_q_in   = '0;
            assign ws_in      = w_sum;
            assign cw_neg_in  = cw_neg;
            assign ccw_neg_in = ccw_neg;
            assign none_in    = no_weight;
        end else begin : g_next
            assign cw_rem_in  = cw_rem_reg[k-1];
            assign ccw_rem_in = ccw_rem_reg[k-1];
            assign cw_q_in    = cw_q_reg[k-1];
            assign ccw_q_in   = ccw_q_reg[k-1];
            assign ws_in      = ws_reg[k-1];
            assign cw_neg_in  = cw_neg_reg[k-1];
            assign ccw_neg_in = ccw_neg_reg[k-1];
            assign none_in    = none_reg[k-1];
        end

        assign divisor_sh = SB'(ws_in) << (DIV_STAGES - 1 - k);
        assign cw_ge      = cw_rem_in >= divisor_sh;
        assign ccw_ge     = ccw_rem_in >= divisor_sh;

        always_ff @(posedge aclk) begin
            if (stage_en[k]) begin
                cw_rem_reg[k]  <= cw_ge ? cw_rem_in - divisor_sh : cw_rem_in;
                ccw_rem_reg[k] <= ccw_ge ? ccw_rem_in - divisor_sh : ccw_rem_in;
                cw_q_reg[k]    <= {cw_q_in[LOAD_BITS-2:0], cw_ge};
                ccw_q_reg[k]   <= {ccw_q_in[LOAD_BITS-2:0], ccw_ge};
                ws_reg[k]      <= ws_in;
                cw_neg_reg[k]  <= cw_neg_in;
                ccw_neg_reg[k] <= ccw_neg_in;
                none_reg[k]    <= none_in;
            end
        end
    end

    assign cw_quot       = cw_q_reg[DIV_STAGES-1];
    assign ccw_quot      = ccw_q_reg[DIV_STAGES-1];
    assign cw_neg_out    = cw_neg_reg[DIV_STAGES-1];
    assign ccw_neg_out   = ccw_neg_reg[DIV_STAGES-1];
    assign no_weight_out = none_reg[DIV_STAGES-1];

endmodule

// File: sv/fuzzy_spin_motor_mixer.sv
`timescale 1ns / 1ps
// Top level of the fuzzy spin motor mixer: configuration registers, pipeline
// control and the output register. Depends on fsmm_pkg, fsmm_slope,
// fsmm_weight, fsmm_mix and fsmm_div.
//
// Each gyro item passes through 13 pipeline stages and the output register,
// and a new item can be accepted in every cycle while s_ready is high; a
// stalled output only holds back the stages behind it, and empty stages keep
// filling. The outer sets need WEIGHT_MAX divided by each saturation point: a
// shared bit-serial divider computes both quotients after reset and after every
// write to sat_low or sat_high, and s_ready stays low while it runs. The
// configuration port is always ready; writes to index 7 are ignored.
module fuzzy_spin_motor_mixer import fsmm_pkg::*; #(
    parameter int WEIGHT_MAX   = 1024,
    parameter int READING_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [READING_BITS-1:0]       s_spin_reading,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [LOAD_BITS-1:0]   m_cw_load,
    output logic signed [LOAD_BITS-1:0]   m_ccw_load,
    output logic                          m_no_weight,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

    localparam int WB  = $clog2(WEIGHT_MAX + 1);
    localparam int SB  = WB + OFFSET_BITS + 3;
    localparam int NS  = FRONT_STAGES + DIV_STAGES;

    logic [ZERO_BITS-1:0]           zero_reading_reg;
    logic signed [SAT_LOW_BITS-1:0] sat_low_reg;
    logic [SAT_HIGH_BITS-1:0]       sat_high_reg;
    offsets_t                       offsets_reg;

    logic cfg_write;
    logic slope_restart;
    logic slope_busy;
    logic [WB-1:0] q_lo, q_hi;

    logic [NS-1:0] stage_valid_reg, stage_valid_next;
    logic [NS:0]   stage_en;
    logic          in_accept;

    logic [WB-1:0] w_cw, w_static, w_ccw;
    logic [WB+1:0] w_sum;
    logic [SB-1:0] cw_mag, ccw_mag;
    logic          cw_neg, ccw_neg, mix_none;
    logic [LOAD_BITS-1:0] cw_quot, ccw_quot;
    logic          cw_neg_fin, ccw_neg_fin, none_fin;

    logic                        m_valid_reg, m_valid_next;
    logic signed [LOAD_BITS-1:0] cw_load_reg, cw_load_next;
    logic signed [LOAD_BITS-1:0] ccw_load_reg, ccw_load_next;
    logic                        no_weight_reg, no_weight_next;

    assign cfg_ready     = 1'b1;
    assign cfg_write     = cfg_valid & cfg_ready;
    assign slope_restart = cfg_write & (cfg_index == REG_SAT_LOW || cfg_index == REG_SAT_HIGH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_reading_reg        <= '0;
            sat_low_reg             <= -16'sd100;
            sat_high_reg            <= 15'd100;
            offsets_reg.cw_neutral  <= 8'sd1;
            offsets_reg.cw_fast     <= 8'sd7;
            offsets_reg.ccw_neutral <= 8'sd1;
            offsets_reg.ccw_fast    <= 8'sd9;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_ZERO_READING:       zero_reading_reg <= cfg_data;
                REG_SAT_LOW:            sat_low_reg <= $signed(cfg_data);
                REG_SAT_HIGH:           sat_high_reg <= cfg_data[SAT_HIGH_BITS-1:0];
                REG_CW_NEUTRAL_OFFSET:  offsets_reg.cw_neutral <= cfg_data[OFFSET_BITS-1:0];
                REG_CW_FAST_OFFSET:     offsets_reg.cw_fast <= cfg_data[OFFSET_BITS-1:0];
                REG_CCW_NEUTRAL_OFFSET: offsets_reg.ccw_neutral <= cfg_data[OFFSET_BITS-1:0];
                REG_CCW_FAST_OFFSET:    offsets_reg.ccw_fast <= cfg_data[OFFSET_BITS-1:0];
                default: ;
            endcase
        end
    end

    fsmm_slope #(
        .WEIGHT_MAX(WEIGHT_MAX)
    ) u_slope (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (slope_restart),
        .sat_low (sat_low_reg),
        .sat_high(sat_high_reg),
        .busy    (slope_busy),
        .q_lo    (q_lo),
        .q_hi    (q_hi)
    );

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        stage_en[NS] = ~m_valid_reg | m_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            stage_en[k] = ~stage_valid_reg[k] | stage_en[k+1];
        end
    end

    assign s_ready   = stage_en[0] & ~slope_busy;
    assign in_accept = s_valid & s_ready;

    always_comb begin
        stage_valid_next[0] = stage_en[0] ? in_accept : stage_valid_reg[0];
        for (int k = 1; k < NS; k++) begin
            stage_valid_next[k] = stage_en[k] ? stage_valid_reg[k-1] : stage_valid_reg[k];
        end
    end

    fsmm_weight #(
        .WEIGHT_MAX  (WEIGHT_MAX),
        .READING_BITS(READING_BITS)
    ) u_weight (
        .aclk        (aclk),
        .stage_en    (stage_en[1:0]),
        .reading     (s_spin_reading),
        .zero_reading(zero_reading_reg),
        .sat_low     (sat_low_reg),
        .sat_high    (sat_high_reg),
        .q_lo        (q_lo),
        .q_hi        (q_hi),
        .w_cw        (w_cw),
        .w_static    (w_static),
        .w_ccw       (w_ccw)
    );

    fsmm_mix #(
        .WEIGHT_MAX(WEIGHT_MAX)
    ) u_mix (
        .aclk     (aclk),
        .stage_en (stage_en[FRONT_STAGES-1:2]),
        .offsets  (offsets_reg),
        .w_cw     (w_cw),
        .w_static (w_static),
        .w_ccw    (w_ccw),
        .w_sum    (w_sum),
        .cw_mag   (cw_mag),
        .ccw_mag  (ccw_mag),
        .cw_neg   (cw_neg),
        .ccw_neg  (ccw_neg),
        .no_weight(mix_none)
    );

    fsmm_div #(
        .WEIGHT_MAX(WEIGHT_MAX)
    ) u_div (
        .aclk         (aclk),
        .stage_en     (stage_en[NS-1:FRONT_STAGES]),
        .w_sum        (w_sum),
        .cw_mag       (cw_mag),
        .ccw_mag      (ccw_mag),
        .cw_neg       (cw_neg),
        .ccw_neg      (ccw_neg),
        .no_weight    (mix_none),
        .cw_quot      (cw_quot),
        .ccw_quot     (ccw_quot),
        .cw_neg_out   (cw_neg_fin),
        .ccw_neg_out  (ccw_neg_fin),
        .no_weight_out(none_fin)
    );

    // With no weight the divider sees a zero divisor, so its quotient is forced off.
    always_comb begin
        m_valid_next   = stage_en[NS] ? stage_valid_reg[NS-1] : m_valid_reg;
        cw_load_next   = cw_load_reg;
        ccw_load_next  = ccw_load_reg;
        no_weight_next = no_weight_reg;
        if (stage_en[NS]) begin
            no_weight_next = none_fin;
            if (none_fin) begin
                cw_load_next  = '0;
                ccw_load_next = '0;
            end else begin
                cw_load_next  = cw_neg_fin ? $signed(LOAD_BITS'(-cw_quot)) : $signed(cw_quot);
                ccw_load_next = ccw_neg_fin ? $signed(LOAD_BITS'(-ccw_quot)) : $signed(ccw_quot);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cw_load_reg   <= cw_load_next;
        ccw_load_reg  <= ccw_load_next;
        no_weight_reg <= no_weight_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_cw_load   = cw_load_reg;
    assign m_ccw_load  = ccw_load_reg;
    assign m_no_weight = no_weight_reg;

`ifndef ASSERT_OFF
    a_no_weight_zero_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_no_weight |-> m_cw_load == '0 && m_ccw_load == '0)
        else $error("no_weight result carries a nonzero load");

    a_slope_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready && (cfg_index == REG_SAT_LOW || cfg_index == REG_SAT_HIGH)
        |=> !s_ready)
        else $error("input accepted while the slopes are being recomputed");

    a_output_from_last_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(stage_valid_reg[NS-1]))
        else $error("result appeared without an item in the last stage");
`endif

endmodule

// File: verif/fuzzy_spin_motor_mixer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for fuzzy_spin_motor_mixer: directed rows, then register
// phases, mostly with random values, with random item content; random stalls on
// both sides, apart from the calm phases. Depends on fsmm_pkg and fuzzy_spin_motor_mixer.
module fuzzy_spin_motor_mixer_tb;
    import fsmm_pkg::*;

    localparam int WEIGHT_MAX    = 1024;
    localparam int READING_BITS  = 16;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 180;
    localparam int HOLD_PHASE    = 5;
    localparam int HOLD_CYCLES   = 200;
    localparam int DRAIN_CYCLES  = 20;
    localparam int TIMEOUT_NS    = 2_000_000;
    localparam int DIRECTED_ROWS = 37;

    localparam cfg_index_t REG_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [LOAD_BITS-1:0] cw;
        logic signed [LOAD_BITS-1:0] ccw;
        logic                        none;
    } loads_t;

    typedef struct packed {
        logic [READING_BITS-1:0] reading;
        loads_t                  want;
    } due_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_TYPED,
        ROW_PREDICTED
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        cfg_index_t             reg_idx;
        logic [CFG_DATA_BITS-1:0] value;
        loads_t                 want;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn;

    logic                        s_valid;
    logic                        s_ready;
    logic [READING_BITS-1:0]     s_spin_reading;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [LOAD_BITS-1:0] m_cw_load;
    logic signed [LOAD_BITS-1:0] m_ccw_load;
    logic                        m_no_weight;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_INDEX_BITS-1:0]   cfg_index;
    logic [CFG_DATA_BITS-1:0]    cfg_data;

    // Register copies used by the load predictor.
    logic [ZERO_BITS-1:0] zero_r;
    int                   sat_low_r;
    int                   sat_high_r;
    offsets_t             offs;

    due_t loads_due_q[$];
    int   mismatch_count = 0;
    bit   calm;
    bit   hold_req;

    // With the reset registers the error is minus the reading. After the first
    // block of writes the wide slopes truncate to zero, so only saturated errors
    // get outer weight. After the second block sat_low is positive and sat_high is zero.
    row_t directed [DIRECTED_ROWS] = '{
        '{ROW_TYPED,     REG_ZERO_READING,       16'd0,     '{8'h01, 8'h01, 1'b0}},
        '{ROW_TYPED,     REG_ZERO_READING,       16'hFFFF,  '{8'h01, 8'h09, 1'b0}},
        '{ROW_TYPED,     REG_ZERO_READING,       16'd100,   '{8'h01, 8'h09, 1'b0}},
        '{ROW_PREDICTED, REG_ZERO_READING,       16'd99,    '0},
        '{ROW_PREDICTED, REG_ZERO_READING,       16'd4,     '0},
        '{ROW_PREDICTED, REG_ZERO_READING,       16'd3,     '0},
        '{ROW_PREDICTED, REG_ZERO_READING,       16'd5,     '0},
        '{ROW_PREDICTED, REG_ZERO_READING,       16'd1,     '0},
        '{ROW_WRITE,     REG_ZERO_READING,       16'h8000,  '0},
        '{ROW_WRITE,     REG_SAT_LOW,            16'h8000,  '0},
        '{ROW_WRITE,     REG_SAT_HIGH,           16'h7FFF,  '0},
        '{ROW_WRITE,     REG_CW_NEUTRAL_OFFSET,  16'h0080,  '0},
        '{ROW_WRITE,     REG_CW_FAST_OFFSET,     16'h007F,  '0},
        '{ROW_WRITE,     REG_CCW_NEUTRAL_OFFSET, 16'h007F,  '0},
        '{ROW_WRITE,     REG_CCW_FAST_OFFSET,    16'h0080,  '0},
        '{ROW_TYPED,     REG_ZERO_READING,       16'h800A,  '{8'h00, 8'h00, 1'b1}},
        '{ROW_TYPED,     REG_ZERO_READING,       16'h7FF6,  '{8'h00, 8'h00, 1'b1}},
        '{ROW_TYPED,     REG_ZERO_READING,       16'h0000,  '{8'h7F, 8'h7F, 1'b0}},
        '{ROW_TYPED,     REG_ZERO_READING,       16'hFFFF,  '{8'h00, 8'h00, 1'b1}},
        '{ROW_TYPED,     REG_ZERO_READING,       16'h8000,  '{8'h80, 8'h7F, 1'b0}},
        '{ROW_PREDICTED, REG_ZERO_READING,       16'h8002,  '0},
        '{ROW_PREDICTED, REG_ZERO_READING,       16'h7FFE,  '0},
        '{ROW_WRITE,     REG_ZERO_READING,       16'd1000,  '0},
        '{ROW_WRITE,     REG_SAT_LOW,            16'd3,     '0},
        '{ROW_WRITE,     REG_SAT_HIGH,           16'h8000,  '0},
        '{ROW_WRITE,     REG_UNUSED,             16'h1234,  '0},
        '{ROW_PREDICTED, REG_ZERO_READING,       16'd1000,  '0},
        '{ROW_PREDICTED, REG_ZERO_READING,       16'd997,   '0},
        '{ROW_TYPED,     REG_ZERO_READING,       16'd996,   '{8'h7F, 8'h7F, 1'b0}},
        '{ROW_PREDICTED, REG_ZERO_READING,       16'd1001,  '0},
        '{ROW_TYPED,     REG_ZERO_READING,       16'd2000,  '{8'h80, 8'h80, 1'b0}},
        '{ROW_WRITE,     REG_SAT_LOW,            16'hFFFF,  '0},
        '{ROW_WRITE,     REG_SAT_HIGH,           16'd1,     '0},
        '{ROW_PREDICTED, REG_ZERO_READING,       16'd1002,  '0},
        '{ROW_PREDICTED, REG_ZERO_READING,       16'd998,   '0},
        '{ROW_PREDICTED, REG_ZERO_READING,       16'd1000,  '0},
        '{ROW_PREDICTED, REG_ZERO_READING,       16'd0,     '0}
    };

    fuzzy_spin_motor_mixer #(
        .WEIGHT_MAX   (WEIGHT_MAX),
        .READING_BITS (READING_BITS)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_spin_reading (s_spin_reading),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cw_load      (m_cw_load),
        .m_ccw_load     (m_ccw_load),
        .m_no_weight    (m_no_weight),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic loads_t mix_loads(input logic [READING_BITS-1:0] reading);
        longint e, w_cw, w_st, w_ccw, w_sum, cw_acc, ccw_acc;
        loads_t r;
        e = longint'(zero_r) - longint'(reading);
        if (e <= sat_low_r) w_cw = WEIGHT_MAX;
        else if (e > 0) w_cw = 0;
        else w_cw = (longint'(WEIGHT_MAX) / longint'(sat_low_r)) * e;
        if (e < -STATIC_HALF || e > STATIC_HALF) w_st = 0;
        else if (e < 0) w_st = (longint'(WEIGHT_MAX) / STATIC_HALF) * (e + STATIC_HALF);
        else w_st = (longint'(WEIGHT_MAX) / -STATIC_HALF) * (e - STATIC_HALF);
        if (e >= sat_high_r) w_ccw = WEIGHT_MAX;
        else if (e < 0) w_ccw = 0;
        else w_ccw = (longint'(WEIGHT_MAX) / longint'(sat_high_r)) * e;
        w_sum = w_cw + w_st + w_ccw;
        cw_acc = (w_cw + w_st) * longint'(offs.cw_neutral) + w_ccw * longint'(offs.cw_fast);
        ccw_acc = w_cw * longint'(offs.ccw_fast)
                + (w_st + w_ccw) * longint'(offs.ccw_neutral);
        r = '0;
        if (w_sum == 0) begin
            r.none = 1'b1;
        end else begin
            r.cw  = LOAD_BITS'(cw_acc / w_sum);
            r.ccw = LOAD_BITS'(ccw_acc / w_sum);
        end
        return r;
    endfunction

    function automatic void apply_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            REG_ZERO_READING:       zero_r = data[ZERO_BITS-1:0];
            REG_SAT_LOW:            sat_low_r = int'($signed(data[SAT_LOW_BITS-1:0]));
            REG_SAT_HIGH:           sat_high_r = int'(data[SAT_HIGH_BITS-1:0]);
            REG_CW_NEUTRAL_OFFSET:  offs.cw_neutral = data[OFFSET_BITS-1:0];
            REG_CW_FAST_OFFSET:     offs.cw_fast = data[OFFSET_BITS-1:0];
            REG_CCW_NEUTRAL_OFFSET: offs.ccw_neutral = data[OFFSET_BITS-1:0];
            REG_CCW_FAST_OFFSET:    offs.ccw_fast = data[OFFSET_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic int idle_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Most readings land near the sloped and saturating regions of the sets.
    function automatic logic [READING_BITS-1:0] pick_reading();
        int lo, hi;
        longint e;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: e = longint'($urandom_range(0, 16)) - 8;
            4, 5, 6, 7: begin
                lo = ((sat_low_r < -STATIC_HALF) ? sat_low_r : -STATIC_HALF) - 3;
                hi = ((sat_high_r > STATIC_HALF) ? sat_high_r : STATIC_HALF) + 3;
                e = lo + longint'($urandom_range(0, hi - lo));
            end
            default: return READING_BITS'($urandom);
        endcase
        return READING_BITS'(longint'(zero_r) - e);
    endfunction

    task automatic send_item(input logic [READING_BITS-1:0] reading, input bit typed,
                             input loads_t want);
        int gap;
        if (cfg_valid) cfg_valid <= 1'b0;
        s_valid <= 1'b1;
        s_spin_reading <= reading;
        do @(posedge aclk); while (!s_ready);
        loads_due_q.push_back('{reading: reading, want: typed ? want : mix_loads(reading)});
        gap = calm ? 0 : idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, data);
    endtask

    // Every item yields one result, so an empty queue means an empty pipeline.
    task automatic wait_idle();
        if (s_valid) s_valid <= 1'b0;
        while (loads_due_q.size() != 0) @(posedge aclk);
    endtask

    task automatic run_phase(input int ph);
        logic [CFG_DATA_BITS-1:0] zr, sl, sh;
        logic [CFG_DATA_BITS-1:0] cwn, cwf, ccwn, ccwf;
        int n;
        wait_idle();
        calm = (ph % 4 == 1);
        zr = CFG_DATA_BITS'($urandom);
        cwn = CFG_DATA_BITS'($urandom);
        cwf = CFG_DATA_BITS'($urandom);
        ccwn = CFG_DATA_BITS'($urandom);
        ccwf = CFG_DATA_BITS'($urandom);
        sl = CFG_DATA_BITS'(-int'($urandom_range(5, 32768)));
        sh = {1'($urandom), 15'($urandom_range(5, 32767))};
        case (ph)
            0: begin
                zr = 16'hFFFF;
                sl = 16'h8000;
                sh = 16'h7FFF;
                {cwn, cwf, ccwn, ccwf} = {16'h0080, 16'h007F, 16'h0080, 16'h007F};
            end
            1: begin
                zr = 16'h0000;
                sl = 16'hFFFB;
                sh = 16'd5;
                {cwn, cwf, ccwn, ccwf} = {16'h007F, 16'h0080, 16'h007F, 16'h0080};
            end
            // A non-negative sat_low and a zero sat_high overlap the outer sets.
            2: begin
                sl = CFG_DATA_BITS'($urandom_range(0, 100));
                sh = {1'($urandom), 15'd0};
            end
            3: begin
                sl = CFG_DATA_BITS'(-int'($urandom_range(1, 4)));
                sh = CFG_DATA_BITS'($urandom_range(1, 4));
            end
            default: ;
        endcase
        write_reg(REG_ZERO_READING, zr);
        write_reg(REG_SAT_LOW, sl);
        write_reg(REG_SAT_HIGH, sh);
        write_reg(REG_CW_NEUTRAL_OFFSET, cwn);
        write_reg(REG_CW_FAST_OFFSET, cwf);
        write_reg(REG_CCW_NEUTRAL_OFFSET, ccwn);
        write_reg(REG_CCW_FAST_OFFSET, ccwf);
        if ($urandom_range(0, 1)) write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom));
        for (n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == HOLD_PHASE && n == 30) hold_req = 1'b1;
            send_item(pick_reading(), 1'b0, '0);
        end
    endtask

    initial begin
        int k, ph;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_spin_reading = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        calm = 1'b0;
        hold_req = 1'b0;
        zero_r = '0;
        sat_low_r = -100;
        sat_high_r = 100;
        offs = '{cw_neutral: 8'sd1, cw_fast: 8'sd7, ccw_neutral: 8'sd1, ccw_fast: 8'sd9};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < DIRECTED_ROWS; k++) begin
            case (directed[k].kind)
                ROW_WRITE: begin
                    wait_idle();
                    write_reg(directed[k].reg_idx, directed[k].value);
                end
                ROW_TYPED: send_item(directed[k].value, 1'b1, directed[k].want);
                default:   send_item(directed[k].value, 1'b0, '0);
            endcase
        end
        for (ph = 0; ph < PHASES; ph++) run_phase(ph);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && loads_due_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // The long hold-off lets the pipeline fill so that s_ready drops.
    initial begin : receiver
        int stall;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                stall = calm ? 0 : idle_gap();
                if (stall == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    repeat (stall - 1) @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin : check_loads
        due_t due;
        if (aresetn && m_valid && m_ready) begin
            if (loads_due_q.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected item: cw %0d ccw %0d none %0b",
                             m_cw_load, m_ccw_load, m_no_weight);
                mismatch_count++;
            end else begin
                due = loads_due_q.pop_front();
                if (due.want.cw !== m_cw_load || due.want.ccw !== m_ccw_load
                        || due.want.none !== m_no_weight) begin
                    if (mismatch_count < 10)
                        $display("reading %0d: expected cw %0d ccw %0d none %0b, got %0d %0d %0b",
                                 due.reading, due.want.cw, due.want.ccw, due.want.none,
                                 m_cw_load, m_ccw_load, m_no_weight);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
sv/fsmm_pkg.sv
sv/fsmm_slope.sv
sv/fsmm_weight.sv
sv/fsmm_mix.sv
sv/fsmm_div.sv
sv/fuzzy_spin_motor_mixer.sv
verif/fuzzy_spin_motor_mixer_tb.sv
